>>> hdl/trsmm_pkg.sv
// ----------------------------------------------------------------------------
// trsmm_pkg: shared types and arithmetic helpers for the TRS model matrix
// Item and result words, inter-stage words, and the rotation term helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package trsmm_pkg;

  localparam int unsigned QW = 16;  // quaternion part width, Q2.14
  localparam int unsigned FW = 32;  // Q16.16 width
  localparam int unsigned PW = 32;  // quaternion product width, Q4.28
  localparam int unsigned TW = 34;  // exact rotation term width, 28 fraction bits
  localparam int unsigned RW = 30;  // rounded rotation term width, 24 fraction bits
  localparam int unsigned MW = RW + FW;  // scaled product width, 40 fraction bits
  localparam int unsigned QTW = MW - 24; // product rounded to 16 fraction bits

  localparam logic signed [TW-1:0] OneQ28 = TW'(64'sd268435456);
  localparam logic signed [TW-1:0] HalfQ4 = TW'(64'sd8);
  localparam logic signed [MW-1:0] HalfQ24 = MW'(64'sd8388608);
  localparam logic signed [FW-1:0] SatMax = 32'sh7FFF_FFFF;
  localparam logic signed [FW-1:0] SatMin = 32'sh8000_0000;

  typedef struct packed {
    logic signed [FW-1:0] pos_x;
    logic signed [FW-1:0] pos_y;
    logic signed [FW-1:0] pos_z;
    logic signed [QW-1:0] rot_w;
    logic signed [QW-1:0] rot_x;
    logic signed [QW-1:0] rot_y;
    logic signed [QW-1:0] rot_z;
    logic signed [FW-1:0] scale_x;
    logic signed [FW-1:0] scale_y;
    logic signed [FW-1:0] scale_z;
  } trsmm_item_t;

  typedef struct packed {
    logic signed [FW-1:0] m00;
    logic signed [FW-1:0] m01;
    logic signed [FW-1:0] m02;
    logic signed [FW-1:0] m10;
    logic signed [FW-1:0] m11;
    logic signed [FW-1:0] m12;
    logic signed [FW-1:0] m20;
    logic signed [FW-1:0] m21;
    logic signed [FW-1:0] m22;
    logic signed [FW-1:0] tr_x;
    logic signed [FW-1:0] tr_y;
    logic signed [FW-1:0] tr_z;
  } trsmm_mat_t;

  // Rounded rotation terms, column-major, with the values that ride along.
  typedef struct packed {
    logic signed [RW-1:0] t00;
    logic signed [RW-1:0] t01;
    logic signed [RW-1:0] t02;
    logic signed [RW-1:0] t10;
    logic signed [RW-1:0] t11;
    logic signed [RW-1:0] t12;
    logic signed [RW-1:0] t20;
    logic signed [RW-1:0] t21;
    logic signed [RW-1:0] t22;
    logic signed [FW-1:0] scale_x;
    logic signed [FW-1:0] scale_y;
    logic signed [FW-1:0] scale_z;
    logic signed [FW-1:0] pos_x;
    logic signed [FW-1:0] pos_y;
    logic signed [FW-1:0] pos_z;
  } trsmm_terms_t;

  // 2*(a+b) or 2*(a-b), exact.
  function automatic logic signed [TW-1:0] twice_pair(input logic signed [PW-1:0] a,
                                                       input logic signed [PW-1:0] b,
                                                       input logic neg);
    logic signed [PW:0] s;
    s = neg ? ((PW+1)'(a) - (PW+1)'(b)) : ((PW+1)'(a) + (PW+1)'(b));
    return $signed({s, 1'b0});
  endfunction

  // 1 - 2*(a+b), exact.
  function automatic logic signed [TW-1:0] diag_term(input logic signed [PW-1:0] a,
                                                      input logic signed [PW-1:0] b);
    return OneQ28 - twice_pair(a, b, 1'b0);
  endfunction

  // Drop 4 fraction bits, round half up.
  function automatic logic signed [RW-1:0] round_term(input logic signed [TW-1:0] t);
    logic signed [TW-1:0] r;
    r = t + HalfQ4;
    return r[TW-1:4];
  endfunction

  // Drop 24 fraction bits, round half up, saturate to 32 bits.
  function automatic logic signed [FW-1:0] round_sat(input logic signed [MW-1:0] p);
    logic signed [MW-1:0] r;
    logic signed [QTW-1:0] q;
    r = p + HalfQ24;
    q = r[MW-1:24];
    if (q > QTW'(SatMax)) begin
      return SatMax;
    end else if (q < QTW'(SatMin)) begin
      return SatMin;
    end
    return q[FW-1:0];
  endfunction

endpackage

`default_nettype wire

>>> hdl/trsmm_rot_terms.sv
// ----------------------------------------------------------------------------
// trsmm_rot_terms: quaternion products and rotation matrix terms
// Two register stages: nine 16x16 products, then the rounded matrix terms.
// ----------------------------------------------------------------------------
`default_nettype none

module trsmm_rot_terms (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        item_valid,
  output logic                       item_ready,
  input  trsmm_pkg::trsmm_item_t     item,
  output logic                       terms_valid,
  input  wire                        terms_ready,
  output trsmm_pkg::trsmm_terms_t    terms
);
  import trsmm_pkg::*;

  typedef struct packed {
    logic signed [PW-1:0] xx;
    logic signed [PW-1:0] yy;
    logic signed [PW-1:0] zz;
    logic signed [PW-1:0] xy;
    logic signed [PW-1:0] xz;
    logic signed [PW-1:0] yz;
    logic signed [PW-1:0] wx;
    logic signed [PW-1:0] wy;
    logic signed [PW-1:0] wz;
    logic signed [FW-1:0] scale_x;
    logic signed [FW-1:0] scale_y;
    logic signed [FW-1:0] scale_z;
    logic signed [FW-1:0] pos_x;
    logic signed [FW-1:0] pos_y;
    logic signed [FW-1:0] pos_z;
  } prod_t;

  prod_t prod;
  logic  prod_valid;
  logic  prod_ready;

  assign item_ready = !prod_valid || prod_ready;
  assign prod_ready = !terms_valid || terms_ready;

  // Stage 1: products
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (item_ready) begin
      prod_valid <= item_valid;
    end
    if (item_ready && item_valid) begin
      prod.xx      <= PW'(item.rot_x) * PW'(item.rot_x);
      prod.yy      <= PW'(item.rot_y) * PW'(item.rot_y);
      prod.zz      <= PW'(item.rot_z) * PW'(item.rot_z);
      prod.xy      <= PW'(item.rot_x) * PW'(item.rot_y);
      prod.xz      <= PW'(item.rot_x) * PW'(item.rot_z);
      prod.yz      <= PW'(item.rot_y) * PW'(item.rot_z);
      prod.wx      <= PW'(item.rot_w) * PW'(item.rot_x);
      prod.wy      <= PW'(item.rot_w) * PW'(item.rot_y);
      prod.wz      <= PW'(item.rot_w) * PW'(item.rot_z);
      prod.scale_x <= item.scale_x;
      prod.scale_y <= item.scale_y;
      prod.scale_z <= item.scale_z;
      prod.pos_x   <= item.pos_x;
      prod.pos_y   <= item.pos_y;
      prod.pos_z   <= item.pos_z;
    end
  end

  // Stage 2: rotation terms, rounded to 24 fraction bits
  always_ff @(posedge clk) begin
    if (rst) begin
      terms_valid <= 1'b0;
    end else if (prod_ready) begin
      terms_valid <= prod_valid;
    end
    if (prod_ready && prod_valid) begin
      terms.t00     <= round_term(diag_term(prod.yy, prod.zz));
      terms.t01     <= round_term(twice_pair(prod.xy, prod.wz, 1'b0));
      terms.t02     <= round_term(twice_pair(prod.xz, prod.wy, 1'b1));
      terms.t10     <= round_term(twice_pair(prod.xy, prod.wz, 1'b1));
      terms.t11     <= round_term(diag_term(prod.xx, prod.zz));
      terms.t12     <= round_term(twice_pair(prod.yz, prod.wx, 1'b0));
      terms.t20     <= round_term(twice_pair(prod.xz, prod.wy, 1'b0));
      terms.t21     <= round_term(twice_pair(prod.yz, prod.wx, 1'b1));
      terms.t22     <= round_term(diag_term(prod.xx, prod.yy));
      terms.scale_x <= prod.scale_x;
      terms.scale_y <= prod.scale_y;
      terms.scale_z <= prod.scale_z;
      terms.pos_x   <= prod.pos_x;
      terms.pos_y   <= prod.pos_y;
      terms.pos_z   <= prod.pos_z;
    end
  end

endmodule

`default_nettype wire

>>> hdl/trsmm_scale.sv
// ----------------------------------------------------------------------------
// trsmm_scale: per-column scaling, rounding and saturation
// Two register stages: nine 30x32 products, then round and saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module trsmm_scale (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        terms_valid,
  output logic                       terms_ready,
  input  trsmm_pkg::trsmm_terms_t    terms,
  output logic                       mat_valid,
  input  wire                        mat_ready,
  output trsmm_pkg::trsmm_mat_t      mat
);
  import trsmm_pkg::*;

  typedef struct packed {
    logic signed [MW-1:0] p00;
    logic signed [MW-1:0] p01;
    logic signed [MW-1:0] p02;
    logic signed [MW-1:0] p10;
    logic signed [MW-1:0] p11;
    logic signed [MW-1:0] p12;
    logic signed [MW-1:0] p20;
    logic signed [MW-1:0] p21;
    logic signed [MW-1:0] p22;
    logic signed [FW-1:0] pos_x;
    logic signed [FW-1:0] pos_y;
    logic signed [FW-1:0] pos_z;
  } scaled_t;

  scaled_t sc;
  logic    sc_valid;
  logic    sc_ready;

  assign terms_ready = !sc_valid || sc_ready;
  assign sc_ready    = !mat_valid || mat_ready;

  // Stage 3: scale each column
  always_ff @(posedge clk) begin
    if (rst) begin
      sc_valid <= 1'b0;
    end else if (terms_ready) begin
      sc_valid <= terms_valid;
    end
    if (terms_ready && terms_valid) begin
      sc.p00   <= MW'(terms.t00) * MW'(terms.scale_x);
      sc.p01   <= MW'(terms.t01) * MW'(terms.scale_x);
      sc.p02   <= MW'(terms.t02) * MW'(terms.scale_x);
      sc.p10   <= MW'(terms.t10) * MW'(terms.scale_y);
      sc.p11   <= MW'(terms.t11) * MW'(terms.scale_y);
      sc.p12   <= MW'(terms.t12) * MW'(terms.scale_y);
      sc.p20   <= MW'(terms.t20) * MW'(terms.scale_z);
      sc.p21   <= MW'(terms.t21) * MW'(terms.scale_z);
      sc.p22   <= MW'(terms.t22) * MW'(terms.scale_z);
      sc.pos_x <= terms.pos_x;
      sc.pos_y <= terms.pos_y;
      sc.pos_z <= terms.pos_z;
    end
  end

  // Stage 4: round, saturate, hold for the receiver
  always_ff @(posedge clk) begin
    if (rst) begin
      mat_valid <= 1'b0;
    end else if (sc_ready) begin
      mat_valid <= sc_valid;
    end
    if (sc_ready && sc_valid) begin
      mat.m00  <= round_sat(sc.p00);
      mat.m01  <= round_sat(sc.p01);
      mat.m02  <= round_sat(sc.p02);
      mat.m10  <= round_sat(sc.p10);
      mat.m11  <= round_sat(sc.p11);
      mat.m12  <= round_sat(sc.p12);
      mat.m20  <= round_sat(sc.p20);
      mat.m21  <= round_sat(sc.p21);
      mat.m22  <= round_sat(sc.p22);
      mat.tr_x <= sc.pos_x;
      mat.tr_y <= sc.pos_y;
      mat.tr_z <= sc.pos_z;
    end
  end

endmodule

`default_nettype wire

>>> hdl/trs_model_matrix.sv
// ----------------------------------------------------------------------------
// trs_model_matrix: fixed-point TRS model matrix from position, quaternion
// and per-axis scale.
//
// Input channel (item_valid / item_ready / item): one word carries a Q16.16
// position, a Q2.14 quaternion (w,x,y,z) and a Q16.16 scale per axis.
// Output channel (mat_valid / mat_ready / mat): one word carries the upper
// 3x3 of T*R*S column-major (m<col><row>), saturated Q16.16, plus the
// translation column. The bottom row 0,0,0,1 is implied and not sent.
// The quaternion is used as given, with no normalization.
//
// Pipeline: one register stage each for quaternion products, rotation
// terms, scale multiplies, and round/saturate.
// Throughput: one word per cycle while the receiver does not stall; each
// stage takes a new word whenever it is empty or its contents move on in
// the same cycle.
//
// Reset (rst, synchronous) drops every word in flight; item_ready is high
// right after. When the receiver stalls, the last stage holds its word and
// the stall backs up stage by stage; no word is lost or repeated, and
// item_ready falls only once all four stages are full.
// ----------------------------------------------------------------------------
`default_nettype none

module trs_model_matrix (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        item_valid,
  output logic                       item_ready,
  input  trsmm_pkg::trsmm_item_t     item,
  output logic                       mat_valid,
  input  wire                        mat_ready,
  output trsmm_pkg::trsmm_mat_t      mat
);
  import trsmm_pkg::*;

  trsmm_terms_t terms;
  logic         terms_valid;
  logic         terms_ready;

  // Front half: quaternion products and rotation terms
  trsmm_rot_terms u_rot_terms (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .terms_valid (terms_valid),
    .terms_ready (terms_ready),
    .terms       (terms)
  );

  // Back half: scale, round, saturate, and the output register
  trsmm_scale u_scale (
    .clk         (clk),
    .rst         (rst),
    .terms_valid (terms_valid),
    .terms_ready (terms_ready),
    .terms       (terms),
    .mat_valid   (mat_valid),
    .mat_ready   (mat_ready),
    .mat         (mat)
  );

endmodule

`default_nettype wire
